[hw/rtl/capsule_support_and_bounds_assert.svh]
// Assertion macros for the capsule geometry query block.
// Expects clk and rst_n in the scope of the module that includes this file.
`ifndef CAPSULE_SUPPORT_AND_BOUNDS_ASSERT_SVH
`define CAPSULE_SUPPORT_AND_BOUNDS_ASSERT_SVH

// same-cycle implication, ignored while in reset
`define CSAB_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("capsule query check failed");

// next-cycle implication, ignored while in reset
`define CSAB_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("capsule query check failed");

`endif

[hw/rtl/csab_pkg.sv]
// Shared widths, codes and helpers for the capsule geometry query block.
// No dependencies; imported by capsule_support_and_bounds.
package csab_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;
  localparam int RAD_W      = 31;  // radius and half height, unsigned Q15.16

  localparam logic [CFG_IDX_W-1:0] REG_RADIUS      = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_HALF_HEIGHT = CFG_IDX_W'(1);
  localparam logic [RAD_W-1:0]     RAD_RESET       = RAD_W'(65536);

  // opcodes
  localparam logic OP_SUPPORT = 1'b0;
  localparam logic OP_BOUNDS  = 1'b1;

  // field widths
  localparam int Q_W     = 18;  // quaternion and direction, signed Q1.16
  localparam int SC_W    = 24;  // bound scale, unsigned Q8.16
  localparam int POS_W   = 32;  // position and results, signed Q16.16

  // internal widths
  localparam int QP_W    = 2 * Q_W;          // quaternion part products
  localparam int AXQ_W   = 22;               // unit axis in Q.16
  localparam int OPR_W   = RAD_W + 1 + AXQ_W; // half_height * axis
  localparam int O_W     = OPR_W - 16;       // scaled axis, Q16.16
  localparam int RDP_W   = RAD_W + 1 + Q_W;  // radius * dir
  localparam int RD_W    = RDP_W - 16;
  localparam int DP_W    = Q_W + O_W;        // dir * axis products
  localparam int DOT_W   = DP_W + 2;
  localparam int BASE_W  = O_W + 1;          // |o| + radius
  localparam int EPR_W   = BASE_W + SC_W;    // base * scale
  localparam int EXT_W   = EPR_W - 16;       // extent, unsigned
  localparam int SUM_W   = 48;               // pre-saturation sums

  localparam logic signed [POS_W-1:0] SAT_HI = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic signed [POS_W-1:0] SAT_LO = {1'b1, {(POS_W-1){1'b0}}};

  // clamp a wide signed sum into the signed 32-bit range
  function automatic logic signed [POS_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
    logic hi_ones;
    logic hi_zeros;
    hi_ones  = &v[SUM_W-1:POS_W-1];
    hi_zeros = ~|v[SUM_W-1:POS_W-1];
    if (hi_ones || hi_zeros) begin
      return v[POS_W-1:0];
    end else if (v[SUM_W-1]) begin
      return SAT_LO;
    end else begin
      return SAT_HI;
    end
  endfunction

endpackage

[hw/rtl/capsule_support_and_bounds.sv]
// Capsule collider geometry query: support point and axis-aligned bounds.
// Depends on csab_pkg and capsule_support_and_bounds_assert.svh.
//
// Usage:
//   Queries enter on the command channel: a word is taken at every rising
//   edge with start high and busy low. busy stays low, so one query can be
//   issued every cycle. Each query carries the pose (quaternion, position)
//   and either a search direction (support) or a scale (bounds).
//   Radius and half height are set on the cfg_ channel (index 0 radius,
//   index 1 half height); cfg_ready is always high. Write them only while
//   no query is in flight.
//   Results leave through the register stages below: out_valid pulses for
//   one cycle with the result word, in query order. The receiver cannot
//   stall; every word must be taken the cycle it is shown.
//   Throughput is one query per cycle. Latency is set by the four register
//   stages: quaternion products, axis scaling, direction/extent products,
//   final sums with saturation.
//   Synchronous reset clears all valid bits (in-flight queries are dropped)
//   and sets radius and half height to 1.0.
`include "capsule_support_and_bounds_assert.svh"

module capsule_support_and_bounds
  import csab_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst_n,
  // command channel
  input  logic                         start,
  output logic                         busy,
  input  logic                         in_opcode,
  input  logic signed [Q_W-1:0]        in_dir_x,
  input  logic signed [Q_W-1:0]        in_dir_y,
  input  logic signed [Q_W-1:0]        in_dir_z,
  input  logic        [SC_W-1:0]       in_scale,
  input  logic signed [Q_W-1:0]        in_rot_w,
  input  logic signed [Q_W-1:0]        in_rot_x,
  input  logic signed [Q_W-1:0]        in_rot_y,
  input  logic signed [Q_W-1:0]        in_rot_z,
  input  logic signed [POS_W-1:0]      in_pos_x,
  input  logic signed [POS_W-1:0]      in_pos_y,
  input  logic signed [POS_W-1:0]      in_pos_z,
  // result channel
  output logic                         out_valid,
  output logic signed [POS_W-1:0]      out_first_x,
  output logic signed [POS_W-1:0]      out_first_y,
  output logic signed [POS_W-1:0]      out_first_z,
  output logic signed [POS_W-1:0]      out_second_x,
  output logic signed [POS_W-1:0]      out_second_y,
  output logic signed [POS_W-1:0]      out_second_z,
  // configuration channel
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic        [CFG_IDX_W-1:0]  cfg_index,
  input  logic        [CFG_DATA_W-1:0] cfg_data
);

  localparam logic signed [QP_W+1:0] ONE_Q31 = (QP_W+2)'(64'sh8000_0000);

  // ---------------------------------------------------------------
  // configuration registers
  logic [RAD_W-1:0] radius_r;
  logic [RAD_W-1:0] half_height_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r      <= RAD_RESET;
      half_height_r <= RAD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_RADIUS:      radius_r      <= cfg_data[RAD_W-1:0];
        REG_HALF_HEIGHT: half_height_r <= cfg_data[RAD_W-1:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  logic accept;
  assign accept = start && !busy;

  // ---------------------------------------------------------------
  // valid bits, one per stage
  logic v1_r, v2_r, v3_r, out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= accept;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      out_valid_r <= v3_r;
    end
  end

  // ---------------------------------------------------------------
  // stage 1: quaternion part products
  logic                     op1_r;
  logic signed [Q_W-1:0]    d1_r [3];
  logic        [SC_W-1:0]   sc1_r;
  logic signed [POS_W-1:0]  p1_r [3];
  logic signed [QP_W-1:0]   xy1_r, wz1_r, xx1_r, zz1_r, yz1_r, wx1_r;

  always_ff @(posedge clk) begin
    op1_r   <= in_opcode;
    d1_r[0] <= in_dir_x;
    d1_r[1] <= in_dir_y;
    d1_r[2] <= in_dir_z;
    sc1_r   <= in_scale;
    p1_r[0] <= in_pos_x;
    p1_r[1] <= in_pos_y;
    p1_r[2] <= in_pos_z;
    xy1_r   <= QP_W'(in_rot_x) * QP_W'(in_rot_y);
    wz1_r   <= QP_W'(in_rot_w) * QP_W'(in_rot_z);
    xx1_r   <= QP_W'(in_rot_x) * QP_W'(in_rot_x);
    zz1_r   <= QP_W'(in_rot_z) * QP_W'(in_rot_z);
    yz1_r   <= QP_W'(in_rot_y) * QP_W'(in_rot_z);
    wx1_r   <= QP_W'(in_rot_w) * QP_W'(in_rot_x);
  end

  // ---------------------------------------------------------------
  // stage 2: unit axis to Q.16, scale by half height; radius * dir
  logic signed [QP_W:0]     diff0, sum2;
  logic signed [QP_W+1:0]   t1;
  logic signed [AXQ_W-1:0]  u2 [3];
  logic signed [OPR_W-1:0]  oprod [3];
  logic signed [RDP_W-1:0]  rdprod [3];

  always_comb begin
    // 2(xy-wz) >> 16 is (xy-wz) >> 15, floor by taking upper bits
    diff0 = (QP_W+1)'(xy1_r) - (QP_W+1)'(wz1_r);
    sum2  = (QP_W+1)'(yz1_r) + (QP_W+1)'(wx1_r);
    t1    = ONE_Q31 - ((QP_W+2)'(xx1_r) + (QP_W+2)'(zz1_r));
    u2[0] = diff0[AXQ_W+14:15];
    u2[1] = t1[AXQ_W+14:15];
    u2[2] = sum2[AXQ_W+14:15];
    for (int i = 0; i < 3; i++) begin
      oprod[i]  = OPR_W'($signed({1'b0, half_height_r})) * OPR_W'(u2[i]);
      rdprod[i] = RDP_W'($signed({1'b0, radius_r})) * RDP_W'(d1_r[i]);
    end
  end

  logic                     op2_r;
  logic signed [Q_W-1:0]    d2_r  [3];
  logic        [SC_W-1:0]   sc2_r;
  logic signed [POS_W-1:0]  p2_r  [3];
  logic signed [O_W-1:0]    o2_r  [3];
  logic signed [RD_W-1:0]   rd2_r [3];

  always_ff @(posedge clk) begin
    op2_r <= op1_r;
    sc2_r <= sc1_r;
    for (int i = 0; i < 3; i++) begin
      d2_r[i]  <= d1_r[i];
      p2_r[i]  <= p1_r[i];
      o2_r[i]  <= oprod[i][OPR_W-1:16];
      rd2_r[i] <= rdprod[i][RDP_W-1:16];
    end
  end

  // ---------------------------------------------------------------
  // stage 3: dir.axis products, extent products, both support sums
  logic signed [DP_W-1:0]   dprod [3];
  logic signed [O_W-1:0]    abs_o [3];
  logic        [BASE_W-1:0] base  [3];
  logic        [EPR_W-1:0]  eprod [3];
  logic signed [SUM_W-1:0]  pr    [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dprod[i] = DP_W'(d2_r[i]) * DP_W'(o2_r[i]);
      abs_o[i] = o2_r[i][O_W-1] ? -o2_r[i] : o2_r[i];
      base[i]  = BASE_W'(unsigned'(abs_o[i])) + BASE_W'(radius_r);
      eprod[i] = EPR_W'(base[i]) * EPR_W'(sc2_r);
      pr[i]    = SUM_W'(p2_r[i]) + SUM_W'(rd2_r[i]);
    end
  end

  logic                     op3_r;
  logic signed [POS_W-1:0]  p3_r   [3];
  logic signed [DP_W-1:0]   dp3_r  [3];
  logic        [EXT_W-1:0]  ext3_r [3];
  logic signed [SUM_W-1:0]  sp3_r  [3];
  logic signed [SUM_W-1:0]  sm3_r  [3];

  always_ff @(posedge clk) begin
    op3_r <= op2_r;
    for (int i = 0; i < 3; i++) begin
      p3_r[i]   <= p2_r[i];
      dp3_r[i]  <= dprod[i];
      ext3_r[i] <= eprod[i][EPR_W-1:16];
      sp3_r[i]  <= pr[i] + SUM_W'(o2_r[i]);
      sm3_r[i]  <= pr[i] - SUM_W'(o2_r[i]);
    end
  end

  // ---------------------------------------------------------------
  // stage 4: dot sign, corner sums, saturation
  logic signed [DOT_W-1:0]  dot;
  logic                     plus;
  logic signed [SUM_W-1:0]  lo_sum [3];
  logic signed [SUM_W-1:0]  hi_sum [3];
  logic signed [POS_W-1:0]  first_nxt  [3];
  logic signed [POS_W-1:0]  second_nxt [3];

  always_comb begin
    dot  = DOT_W'(dp3_r[0]) + DOT_W'(dp3_r[1]) + DOT_W'(dp3_r[2]);
    plus = !dot[DOT_W-1] && (dot != '0);
    for (int i = 0; i < 3; i++) begin
      lo_sum[i] = SUM_W'(p3_r[i]) - $signed(SUM_W'(ext3_r[i]));
      hi_sum[i] = SUM_W'(p3_r[i]) + $signed(SUM_W'(ext3_r[i]));
      if (op3_r == OP_BOUNDS) begin
        first_nxt[i]  = sat32(lo_sum[i]);
        second_nxt[i] = sat32(hi_sum[i]);
      end else begin
        first_nxt[i]  = sat32(plus ? sp3_r[i] : sm3_r[i]);
        second_nxt[i] = '0;
      end
    end
  end

  logic                     op4_r;
  logic signed [POS_W-1:0]  first_r  [3];
  logic signed [POS_W-1:0]  second_r [3];

  always_ff @(posedge clk) begin
    op4_r <= op3_r;
    for (int i = 0; i < 3; i++) begin
      first_r[i]  <= first_nxt[i];
      second_r[i] <= second_nxt[i];
    end
  end

  // result word
  assign out_valid    = out_valid_r;
  assign out_first_x  = first_r[0];
  assign out_first_y  = first_r[1];
  assign out_first_z  = first_r[2];
  assign out_second_x = second_r[0];
  assign out_second_y = second_r[1];
  assign out_second_z = second_r[2];

  // ---------------------------------------------------------------
  // checks
  `CSAB_IMPLY(a_out_follows_start, out_valid, $past(start, 4))
  `CSAB_IMPLY(a_support_second_zero, out_valid && (op4_r == OP_SUPPORT),
    (out_second_x == '0) && (out_second_y == '0) && (out_second_z == '0))
  `CSAB_IMPLY(a_bounds_ordered, out_valid && (op4_r == OP_BOUNDS),
    (out_first_x <= out_second_x) && (out_first_y <= out_second_y) &&
    (out_first_z <= out_second_z))
  `CSAB_NEXT(a_cfg_radius_write, cfg_valid && cfg_ready && (cfg_index == REG_RADIUS),
    radius_r == $past(cfg_data[RAD_W-1:0]))

endmodule

[dv/tb_capsule_support_and_bounds.sv]
`timescale 1ns / 100ps
// Self-checking bench for capsule_support_and_bounds: support and bounds queries
// under several radius / half height settings, every result word checked.
// Depends on csab_pkg and the block's RTL only.

module tb_capsule_support_and_bounds
  import csab_pkg::*;
();

  localparam int LIMIT_CYCLES   = 400000;
  localparam int RAND_PER_PHASE = 200;
  localparam int NUM_PHASES     = 8;

  localparam int Q_MIN  = -(2 ** (Q_W - 1));
  localparam int Q_MAX  = 2 ** (Q_W - 1) - 1;
  localparam int ONE    = 65536;
  localparam int COS45  = 46341;
  localparam int SC_MAX = 2 ** SC_W - 1;

  typedef struct {
    logic                    opcode;
    logic signed [Q_W-1:0]   dir_x, dir_y, dir_z;
    logic        [SC_W-1:0]  scale;
    logic signed [Q_W-1:0]   rot_w, rot_x, rot_y, rot_z;
    logic signed [POS_W-1:0] pos_x, pos_y, pos_z;
  } query_t;

  typedef struct {
    logic                    opcode;
    logic signed [POS_W-1:0] first_x, first_y, first_z;
    logic signed [POS_W-1:0] second_x, second_y, second_z;
  } answer_t;

  logic                         clk;
  logic                         rst_n;
  logic                         start;
  logic                         busy;
  logic                         in_opcode;
  logic signed [Q_W-1:0]        in_dir_x, in_dir_y, in_dir_z;
  logic        [SC_W-1:0]       in_scale;
  logic signed [Q_W-1:0]        in_rot_w, in_rot_x, in_rot_y, in_rot_z;
  logic signed [POS_W-1:0]      in_pos_x, in_pos_y, in_pos_z;
  logic                         out_valid;
  logic signed [POS_W-1:0]      out_first_x, out_first_y, out_first_z;
  logic signed [POS_W-1:0]      out_second_x, out_second_y, out_second_z;
  logic                         cfg_valid;
  logic                         cfg_ready;
  logic        [CFG_IDX_W-1:0]  cfg_index;
  logic        [CFG_DATA_W-1:0] cfg_data;

  capsule_support_and_bounds dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_opcode    (in_opcode),
    .in_dir_x     (in_dir_x),
    .in_dir_y     (in_dir_y),
    .in_dir_z     (in_dir_z),
    .in_scale     (in_scale),
    .in_rot_w     (in_rot_w),
    .in_rot_x     (in_rot_x),
    .in_rot_y     (in_rot_y),
    .in_rot_z     (in_rot_z),
    .in_pos_x     (in_pos_x),
    .in_pos_y     (in_pos_y),
    .in_pos_z     (in_pos_z),
    .out_valid    (out_valid),
    .out_first_x  (out_first_x),
    .out_first_y  (out_first_y),
    .out_first_z  (out_first_z),
    .out_second_x (out_second_x),
    .out_second_y (out_second_y),
    .out_second_z (out_second_z),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // bench copy of the two registers
  logic [RAD_W-1:0] radius_m;
  logic [RAD_W-1:0] half_height_m;

  query_t  queries_todo[$];
  answer_t answers_due[$];
  query_t  cur_q;
  answer_t want;
  int      idle_pct;
  int      mismatches;
  int      support_seen;
  int      bounds_seen;
  int      cycles;

  always #6 clk = ~clk;

  // clamp to signed 32 bits
  function automatic logic signed [POS_W-1:0] clamp32(longint v);
    if (v > longint'(SAT_HI)) return SAT_HI;
    if (v < longint'(SAT_LO)) return SAT_LO;
    return v[POS_W-1:0];
  endfunction

  // expected result word for one query under the current register values
  function automatic answer_t capsule_answer(query_t q);
    longint qw, qx, qy, qz, hh, rad, sc, dotp, ext, mag;
    longint u[3], o[3], d[3], p[3];
    logic signed [POS_W-1:0] lo[3], hi[3];
    logic plus;
    answer_t a;
    qw  = longint'(q.rot_w);
    qx  = longint'(q.rot_x);
    qy  = longint'(q.rot_y);
    qz  = longint'(q.rot_z);
    hh  = longint'(half_height_m);
    rad = longint'(radius_m);
    sc  = longint'(q.scale);
    d[0] = longint'(q.dir_x);  d[1] = longint'(q.dir_y);  d[2] = longint'(q.dir_z);
    p[0] = longint'(q.pos_x);  p[1] = longint'(q.pos_y);  p[2] = longint'(q.pos_z);
    // up axis rotated by the quaternion, Q.32 cut to Q.16 (floor)
    u[0] = (2 * (qx * qy - qw * qz)) >>> 16;
    u[1] = ((longint'(1) <<< 32) - 2 * (qx * qx + qz * qz)) >>> 16;
    u[2] = (2 * (qy * qz + qw * qx)) >>> 16;
    for (int i = 0; i < 3; i++) o[i] = (hh * u[i]) >>> 16;
    dotp = d[0] * o[0] + d[1] * o[1] + d[2] * o[2];
    plus = (dotp > 0);  // a dot of exactly zero subtracts the axis
    for (int i = 0; i < 3; i++) begin
      if (q.opcode == OP_SUPPORT) begin
        lo[i] = clamp32(p[i] + ((rad * d[i]) >>> 16) + (plus ? o[i] : -o[i]));
        hi[i] = '0;
      end else begin
        mag   = (o[i] < 0) ? -o[i] : o[i];
        ext   = ((mag + rad) * sc) >>> 16;
        lo[i] = clamp32(p[i] - ext);
        hi[i] = clamp32(p[i] + ext);
      end
    end
    a.opcode   = q.opcode;
    a.first_x  = lo[0];  a.first_y  = lo[1];  a.first_z  = lo[2];
    a.second_x = hi[0];  a.second_y = hi[1];  a.second_z = hi[2];
    return a;
  endfunction

  function automatic query_t mk_query(logic op, int dx, int dy, int dz, int sc,
                                      int qw, int qx, int qy, int qz,
                                      int px, int py, int pz);
    query_t q;
    q.opcode = op;
    q.dir_x = Q_W'(dx);  q.dir_y = Q_W'(dy);  q.dir_z = Q_W'(dz);
    q.scale = SC_W'(sc);
    q.rot_w = Q_W'(qw);  q.rot_x = Q_W'(qx);  q.rot_y = Q_W'(qy);  q.rot_z = Q_W'(qz);
    q.pos_x = px;  q.pos_y = py;  q.pos_z = pz;
    return q;
  endfunction

  // Q1.16 field: extremes, small values or any pattern
  function automatic logic signed [Q_W-1:0] any_q1();
    logic signed [Q_W-1:0] v;
    v = Q_W'($urandom);
    case ($urandom_range(3))
      0: v = $urandom_range(1) ? Q_W'(Q_MIN) : Q_W'(Q_MAX);
      1: begin
        v = Q_W'($urandom_range(511));
        v = v - Q_W'(256);
      end
      default: ;
    endcase
    return v;
  endfunction

  function automatic logic signed [POS_W-1:0] any_pos();
    logic signed [POS_W-1:0] v;
    v = $urandom;
    case ($urandom_range(9))
      0: v = $urandom_range(1) ? SAT_HI : SAT_LO;
      1, 2, 3, 4, 5, 6: v = v >>> $urandom_range(16, 4);
      default: ;
    endcase
    return v;
  endfunction

  function automatic logic [SC_W-1:0] any_scale();
    case ($urandom_range(9))
      0:             return '0;
      1:             return SC_W'(SC_MAX);
      2, 3, 4, 5, 6: return SC_W'(ONE + $urandom_range(ONE));
      default:       return SC_W'($urandom);
    endcase
  endfunction

  // mostly unit quaternions and directions, the rest raw bit patterns
  function automatic query_t random_query();
    query_t q;
    real    qr[4];
    real    dr[3];
    real    qn, dn;
    qn = 0.0;
    dn = 0.0;
    for (int i = 0; i < 4; i++) begin
      qr[i] = $urandom_range(2000);
      qr[i] = qr[i] - 1000.0;
      qn    = qn + qr[i] * qr[i];
    end
    for (int i = 0; i < 3; i++) begin
      dr[i] = $urandom_range(2000);
      dr[i] = dr[i] - 1000.0;
      dn    = dn + dr[i] * dr[i];
    end
    qn = (qn < 1.0) ? 1.0 : $sqrt(qn);
    dn = (dn < 1.0) ? 1.0 : $sqrt(dn);
    q.opcode = 1'($urandom_range(1));
    if ($urandom_range(99) < 80) begin
      q.rot_w = Q_W'($rtoi(qr[0] / qn * 65536.0));
      q.rot_x = Q_W'($rtoi(qr[1] / qn * 65536.0));
      q.rot_y = Q_W'($rtoi(qr[2] / qn * 65536.0));
      q.rot_z = Q_W'($rtoi(qr[3] / qn * 65536.0));
      q.dir_x = Q_W'($rtoi(dr[0] / dn * 65536.0));
      q.dir_y = Q_W'($rtoi(dr[1] / dn * 65536.0));
      q.dir_z = Q_W'($rtoi(dr[2] / dn * 65536.0));
    end else begin
      q.rot_w = any_q1();  q.rot_x = any_q1();
      q.rot_y = any_q1();  q.rot_z = any_q1();
      q.dir_x = any_q1();  q.dir_y = any_q1();  q.dir_z = any_q1();
    end
    q.scale = any_scale();
    q.pos_x = any_pos();
    q.pos_y = any_pos();
    q.pos_z = any_pos();
    return q;
  endfunction

  task automatic load_directed();
    // identity pose: direction orthogonal, along and against the axis
    queries_todo.push_back(mk_query(OP_SUPPORT, ONE, 0, 0, 0, ONE, 0, 0, 0, 0, 0, 0));
    queries_todo.push_back(mk_query(OP_SUPPORT, 0, ONE, 0, 0, ONE, 0, 0, 0, ONE, -ONE, 7));
    queries_todo.push_back(mk_query(OP_SUPPORT, 0, -ONE, 0, 0, ONE, 0, 0, 0, -3, 5, ONE));
    // zero and non-unit quaternions, used as given
    queries_todo.push_back(mk_query(OP_SUPPORT, 0, 0, ONE, 0, 0, 0, 0, 0, 0, 0, 0));
    queries_todo.push_back(mk_query(OP_SUPPORT, ONE, ONE, 0, 0, Q_MAX, 0, 0, 0, 0, 0, 0));
    queries_todo.push_back(mk_query(OP_SUPPORT, 0, 0, 0, 0, 0, Q_MAX, 0, Q_MAX, 0, 0, 0));
    // field extremes, driving the sums into saturation both ways
    queries_todo.push_back(mk_query(OP_SUPPORT, Q_MIN, Q_MIN, Q_MIN, SC_MAX,
                                    Q_MIN, Q_MIN, Q_MIN, Q_MIN, SAT_HI, SAT_HI, SAT_HI));
    queries_todo.push_back(mk_query(OP_SUPPORT, Q_MAX, Q_MAX, Q_MAX, 0,
                                    Q_MAX, Q_MAX, Q_MAX, Q_MAX, SAT_LO, SAT_LO, SAT_LO));
    queries_todo.push_back(mk_query(OP_SUPPORT, Q_MAX, Q_MIN, Q_MAX, SC_MAX,
                                    Q_MIN, Q_MAX, Q_MIN, Q_MAX, SAT_HI, SAT_LO, 0));
    // quarter turn about z: axis along -x
    queries_todo.push_back(mk_query(OP_SUPPORT, -ONE, 0, 0, 0, COS45, 0, 0, COS45, 0, 0, 0));
    queries_todo.push_back(mk_query(OP_SUPPORT, 0, 0, ONE, 0, COS45, 0, 0, COS45, 0, 0, 0));
    // bounds: zero axis components give radius times scale
    queries_todo.push_back(mk_query(OP_BOUNDS, 0, 0, 0, ONE, ONE, 0, 0, 0, 0, 0, 0));
    queries_todo.push_back(mk_query(OP_BOUNDS, 0, 0, 0, 0, ONE, 0, 0, 0, ONE, ONE, ONE));
    queries_todo.push_back(mk_query(OP_BOUNDS, 0, 0, 0, SC_MAX, ONE, 0, 0, 0,
                                    SAT_HI, SAT_HI, SAT_HI));
    queries_todo.push_back(mk_query(OP_BOUNDS, 0, 0, 0, SC_MAX, ONE, 0, 0, 0,
                                    SAT_LO, SAT_LO, SAT_LO));
    queries_todo.push_back(mk_query(OP_BOUNDS, Q_MIN, Q_MIN, Q_MIN, SC_MAX,
                                    Q_MIN, Q_MIN, Q_MIN, Q_MIN, 0, 0, 0));
    queries_todo.push_back(mk_query(OP_BOUNDS, Q_MAX, Q_MAX, Q_MAX, SC_MAX,
                                    Q_MAX, Q_MAX, Q_MAX, Q_MAX, SAT_HI, SAT_LO, -1));
    queries_todo.push_back(mk_query(OP_BOUNDS, ONE, 0, 0, 2 * ONE, COS45, 0, 0, COS45,
                                    -ONE, 3 * ONE, 0));
    queries_todo.push_back(mk_query(OP_BOUNDS, 0, 0, 0, ONE, 0, 0, 0, 0, 0, 0, 0));
  endtask

  task automatic flag_mismatch(string msg);
    mismatches++;
    $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  task automatic check_field(string name, logic signed [POS_W-1:0] got,
                             logic signed [POS_W-1:0] want_v);
    if (got !== want_v)
      flag_mismatch($sformatf("%s got %0d want %0d", name, got, want_v));
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // idle means no query pending, none on the port and none outstanding
  task automatic wait_drained();
    do @(negedge clk);
    while (queries_todo.size() != 0 || start || answers_due.size() != 0);
  endtask

  // driver: tracks register writes, predicts each accepted word, feeds the next
  always @(posedge clk) begin
    if (!rst_n) begin
      radius_m      = RAD_RESET;
      half_height_m = RAD_RESET;
      start <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_RADIUS) radius_m = cfg_data[RAD_W-1:0];
        else if (cfg_index == REG_HALF_HEIGHT) half_height_m = cfg_data[RAD_W-1:0];
      end
      if (start && !busy) answers_due.push_back(capsule_answer(cur_q));
      if (!start || !busy) begin
        if (queries_todo.size() != 0 && $urandom_range(99) >= idle_pct) begin
          cur_q = queries_todo.pop_front();
          start     <= 1'b1;
          in_opcode <= cur_q.opcode;
          in_dir_x  <= cur_q.dir_x;
          in_dir_y  <= cur_q.dir_y;
          in_dir_z  <= cur_q.dir_z;
          in_scale  <= cur_q.scale;
          in_rot_w  <= cur_q.rot_w;
          in_rot_x  <= cur_q.rot_x;
          in_rot_y  <= cur_q.rot_y;
          in_rot_z  <= cur_q.rot_z;
          in_pos_x  <= cur_q.pos_x;
          in_pos_y  <= cur_q.pos_y;
          in_pos_z  <= cur_q.pos_z;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: every strobed word against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (answers_due.size() == 0) begin
        flag_mismatch("result word with nothing outstanding");
      end else begin
        want = answers_due.pop_front();
        check_field("first_x", out_first_x, want.first_x);
        check_field("first_y", out_first_y, want.first_y);
        check_field("first_z", out_first_z, want.first_z);
        check_field("second_x", out_second_x, want.second_x);
        check_field("second_y", out_second_y, want.second_y);
        check_field("second_z", out_second_z, want.second_z);
        if (want.opcode == OP_SUPPORT) support_seen++;
        else bounds_seen++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("run stopped by watchdog after %0d cycles", cycles);
      $display("capsule_support_and_bounds test failed");
      $finish;
    end
  end

  initial begin
    logic [CFG_DATA_W-1:0] rad_v;
    logic [CFG_DATA_W-1:0] hh_v;
    clk          = 1'b0;
    rst_n        = 1'b0;
    start        = 1'b0;
    in_opcode    = 1'b0;
    in_dir_x     = '0;
    in_dir_y     = '0;
    in_dir_z     = '0;
    in_scale     = '0;
    in_rot_w     = '0;
    in_rot_x     = '0;
    in_rot_y     = '0;
    in_rot_z     = '0;
    in_pos_x     = '0;
    in_pos_y     = '0;
    in_pos_z     = '0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    idle_pct     = 10;
    mismatches   = 0;
    support_seen = 0;
    bounds_seen  = 0;
    cycles       = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed words under the reset register values
    @(negedge clk);
    load_directed();
    wait_drained();

    // random phases, each under its own radius / half height
    for (int ph = 1; ph < NUM_PHASES; ph++) begin
      case (ph)
        1: begin rad_v = '0;            hh_v = '1;            end
        2: begin rad_v = 32'h7FFF_FFFF; hh_v = '0;            end
        3: begin rad_v = 32768;         hh_v = 3 * ONE;       end
        4: begin rad_v = $urandom;      hh_v = $urandom;      end
        5: begin rad_v = '0;            hh_v = '0;            end
        6: begin
          rad_v = $urandom_range(1 << 22);
          hh_v  = $urandom_range(1 << 22);
        end
        default: begin rad_v = RAD_RESET; hh_v = RAD_RESET; end
      endcase
      idle_pct = (ph < 3) ? 10 : (ph < 6) ? 71 : 0;
      write_reg(REG_RADIUS, rad_v);
      write_reg(REG_HALF_HEIGHT, hh_v);
      @(negedge clk);
      repeat (RAND_PER_PHASE) queries_todo.push_back(random_query());
      wait_drained();
    end

    repeat (20) @(posedge clk);
    $display("checked %0d support and %0d bounds words across %0d register settings",
             support_seen, bounds_seen, NUM_PHASES);
    $display("%0d mismatches", mismatches);
    if (mismatches == 0) begin
      $display("capsule_support_and_bounds test passed");
    end else begin
      $display("capsule_support_and_bounds test failed");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/csab_pkg.sv
hw/rtl/capsule_support_and_bounds.sv
dv/tb_capsule_support_and_bounds.sv
